// ===== src/bsm_pkg.sv =====
// Shared constants and the front-to-back command type of the box stacking block.
package bsm_pkg;
  localparam int unsigned MaxBoxesDef = 32;
  localparam int unsigned SideW       = 16;
  localparam int unsigned HeightW     = 23;
  localparam int unsigned WordW       = 3 * SideW;
  localparam logic [HeightW-1:0] HeightMax = {HeightW{1'b1}};

  // One accepted box, classified by the front end.
  typedef struct packed {
    logic [SideW-1:0] side_a;
    logic [SideW-1:0] side_b;
    logic [SideW-1:0] side_c;
    logic             store;  // box fits, keep it
    logic             last;   // close the set and compute
    logic             ovf;    // some box of this set was dropped
  } bsm_cmd_t;
endpackage

// ===== src/box_stacking_max_height.sv =====
// Top level of the box stacking block: front end, command queue, back end.
// Boxes (three 16-bit sides plus a last marker) are taken in one per cycle
// while the two-entry queue has room. For each stored box the back end
// takes it off the queue in S_POP, then writes its three orientations into
// the raw store in S_WR1, S_WR2 and S_WR3. A box that arrives when
// MAX_BOXES boxes are already held in the current set is dropped and the
// set is flagged. The item marked last closes the set: the back end ranks
// every orientation (three per stored box) by base (short side, then long
// side) with one scan of the raw store per orientation, then runs the
// tallest-stack pass with one scan of the earlier ordered entries per
// orientation. Both passes are bounded by one compare per cycle on the
// memory read ports. The result (max_height, saturated at 23 bits, and
// overflowed) is held on the output until taken; meanwhile the front end
// takes boxes of the next set until the two-entry queue is full.
module box_stacking_max_height import bsm_pkg::*; #(
  parameter int unsigned MAX_BOXES = MaxBoxesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SideW-1:0]   side_a_i,
  input  logic [SideW-1:0]   side_b_i,
  input  logic [SideW-1:0]   side_c_i,
  input  logic               last_box_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [HeightW-1:0] max_height_o,
  output logic               overflowed_o
);
  bsm_cmd_t front_cmd, back_cmd;
  logic     front_valid, front_ready, back_valid, back_ready;

  // capacity check and per-set overflow tracking
  bsm_front #(.MAX_BOXES(MAX_BOXES)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .side_a_i, .side_b_i, .side_c_i, .last_box_i,
    .cmd_valid_o(front_valid), .cmd_ready_i(front_ready), .cmd_o(front_cmd)
  );

  // decouples box intake from the long compute passes
  bsm_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_valid_i(front_valid), .push_ready_o(front_ready), .push_data_i(front_cmd),
    .pop_valid_o(back_valid), .pop_ready_i(back_ready), .pop_data_o(back_cmd)
  );

  // storage, ranking and the tallest-stack pass
  bsm_back #(.MAX_BOXES(MAX_BOXES)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(back_valid), .cmd_ready_o(back_ready), .cmd_i(back_cmd),
    .out_valid_o, .out_ready_i, .max_height_o, .overflowed_o
  );
endmodule

// ===== src/bsm_front.sv =====
// Front end: accepts boxes, checks capacity, tracks the overflow flag per set.
module bsm_front import bsm_pkg::*; #(
  parameter int unsigned MAX_BOXES = MaxBoxesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SideW-1:0] side_a_i,
  input  logic [SideW-1:0] side_b_i,
  input  logic [SideW-1:0] side_c_i,
  input  logic             last_box_i,
  output logic             cmd_valid_o,
  input  logic             cmd_ready_i,
  output bsm_cmd_t         cmd_o
);
  localparam int unsigned BoxCntW = $clog2(MAX_BOXES + 1);
  localparam logic [BoxCntW-1:0] BoxLimit = BoxCntW'(MAX_BOXES);

  logic [BoxCntW-1:0] box_cnt_q, box_cnt_d;
  logic               ovf_q, ovf_d;
  logic               fits, take;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign take        = in_valid_i && cmd_ready_i;
  assign fits        = box_cnt_q < BoxLimit;

  always_comb begin
    cmd_o.side_a = side_a_i;
    cmd_o.side_b = side_b_i;
    cmd_o.side_c = side_c_i;
    cmd_o.store  = fits;
    cmd_o.last   = last_box_i;
    cmd_o.ovf    = ovf_q || !fits;
    box_cnt_d    = box_cnt_q;
    ovf_d        = ovf_q;
    if (take) begin
      if (last_box_i) begin
        box_cnt_d = '0;
        ovf_d     = 1'b0;
      end else if (fits) begin
        box_cnt_d = box_cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_cnt_q <= '0;
      ovf_q     <= 1'b0;
    end else begin
      box_cnt_q <= box_cnt_d;
      ovf_q     <= ovf_d;
    end
  end
endmodule

// ===== src/bsm_fifo.sv =====
// Two-entry command queue between the front end and the back end.
module bsm_fifo import bsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  bsm_cmd_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output bsm_cmd_t pop_data_o
);
  bsm_cmd_t   data_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'd2;
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_data_o   = data_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) data_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== src/bsm_back.sv =====
// Back end: stores orientations, ranks them by base, runs the stacking pass.
module bsm_back import bsm_pkg::*; #(
  parameter int unsigned MAX_BOXES = MaxBoxesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  bsm_cmd_t           cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [HeightW-1:0] max_height_o,
  output logic               overflowed_o
);
  localparam int unsigned Slots = 3 * MAX_BOXES;
  localparam int unsigned AddrW = $clog2(Slots);
  localparam int unsigned CntW  = $clog2(Slots + 1);

  typedef enum logic [3:0] {
    S_POP, S_WR1, S_WR2, S_WR3, S_RK_LD, S_RK_SCAN, S_RK_WR,
    S_DP_LD, S_DP_SCAN, S_DP_WR, S_OUT
  } state_e;

  state_e state_q;
  bsm_cmd_t cmd_q;
  logic [CntW-1:0] n_q, i_q, j_q, jd_q, rank_q;
  logic vld_q;
  logic [HeightW-1:0] below_q, best_q;

  // raw orientation store, base-ordered store and per-entry stack heights
  logic [WordW-1:0]   raw_mem [Slots];
  logic [WordW-1:0]   srt_mem [Slots];
  logic [HeightW-1:0] bst_mem [Slots];
  logic [WordW-1:0]   raw_a_q, raw_b_q, srt_a_q, srt_b_q;
  logic [HeightW-1:0] bst_b_q;

  logic              raw_we, srt_we, bst_we;
  logic [AddrW-1:0]  raw_waddr, srt_waddr;
  logic [WordW-1:0]  raw_wdata;
  logic [SideW-1:0]  ox, oy, oh;
  logic [HeightW:0]  sum;
  logic [HeightW-1:0] sum_sat;
  logic              issue;

  assign cmd_ready_o  = state_q == S_POP;
  assign out_valid_o  = state_q == S_OUT;
  assign max_height_o = best_q;
  assign overflowed_o = cmd_q.ovf;

  // orientation being written: (a,b | c), (a,c | b), (c,b | a)
  always_comb begin
    unique case (state_q)
      S_WR1:   begin ox = cmd_q.side_a; oy = cmd_q.side_b; oh = cmd_q.side_c; end
      S_WR2:   begin ox = cmd_q.side_a; oy = cmd_q.side_c; oh = cmd_q.side_b; end
      default: begin ox = cmd_q.side_c; oy = cmd_q.side_b; oh = cmd_q.side_a; end
    endcase
    raw_wdata = (ox < oy) ? {ox, oy, oh} : {oy, ox, oh};
  end

  assign raw_we    = (state_q == S_WR1) || (state_q == S_WR2) || (state_q == S_WR3);
  assign raw_waddr = n_q[AddrW-1:0];
  assign srt_we    = state_q == S_RK_WR;
  assign srt_waddr = rank_q[AddrW-1:0];
  assign bst_we    = state_q == S_DP_WR;
  assign issue     = ((state_q == S_RK_SCAN) && (j_q < n_q)) ||
                     ((state_q == S_DP_SCAN) && (j_q < i_q));

  assign sum     = {1'b0, below_q} + (HeightW + 1)'(srt_a_q[SideW-1:0]);
  assign sum_sat = sum[HeightW] ? HeightMax : sum[HeightW-1:0];

  always_ff @(posedge clk_i) begin
    if (raw_we) raw_mem[raw_waddr] <= raw_wdata;
    raw_a_q <= raw_mem[i_q[AddrW-1:0]];
    raw_b_q <= raw_mem[j_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (srt_we) srt_mem[srt_waddr] <= raw_a_q;
    srt_a_q <= srt_mem[i_q[AddrW-1:0]];
    srt_b_q <= srt_mem[j_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (bst_we) bst_mem[i_q[AddrW-1:0]] <= sum_sat;
    bst_b_q <= bst_mem[j_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_POP && cmd_valid_i) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_POP;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      jd_q    <= '0;
      rank_q  <= '0;
      vld_q   <= 1'b0;
      below_q <= '0;
      best_q  <= '0;
    end else begin
      vld_q <= issue;
      jd_q  <= j_q;
      if (issue) j_q <= j_q + 1'b1;
      unique case (state_q)
        S_POP: begin
          if (cmd_valid_i) begin
            if (cmd_i.store)     state_q <= S_WR1;
            else if (cmd_i.last) state_q <= S_RK_LD;
            i_q <= '0;
          end
        end
        S_WR1: begin n_q <= n_q + 1'b1; state_q <= S_WR2; end
        S_WR2: begin n_q <= n_q + 1'b1; state_q <= S_WR3; end
        S_WR3: begin
          n_q     <= n_q + 1'b1;
          state_q <= cmd_q.last ? S_RK_LD : S_POP;
        end
        S_RK_LD: begin
          j_q    <= '0;
          rank_q <= '0;
          best_q <= '0;
          if (i_q == n_q) begin
            i_q     <= '0;
            state_q <= (n_q == '0) ? S_OUT : S_DP_LD;
          end else begin
            state_q <= S_RK_SCAN;
          end
        end
        S_RK_SCAN: begin
          // rank = entries with a smaller key, or an equal key earlier on
          if (vld_q && ((raw_b_q[WordW-1:SideW] < raw_a_q[WordW-1:SideW]) ||
              ((raw_b_q[WordW-1:SideW] == raw_a_q[WordW-1:SideW]) && (jd_q < i_q))))
            rank_q <= rank_q + 1'b1;
          if (!issue && !vld_q) state_q <= S_RK_WR;
        end
        S_RK_WR: begin
          i_q     <= i_q + 1'b1;
          state_q <= S_RK_LD;
        end
        S_DP_LD: begin
          j_q     <= '0;
          below_q <= '0;
          state_q <= S_DP_SCAN;
        end
        S_DP_SCAN: begin
          if (vld_q &&
              (srt_b_q[WordW-1:2*SideW] < srt_a_q[WordW-1:2*SideW]) &&
              (srt_b_q[2*SideW-1:SideW] < srt_a_q[2*SideW-1:SideW]) &&
              (bst_b_q > below_q))
            below_q <= bst_b_q;
          if (!issue && !vld_q) state_q <= S_DP_WR;
        end
        S_DP_WR: begin
          if (sum_sat > best_q) best_q <= sum_sat;
          i_q     <= i_q + 1'b1;
          state_q <= (i_q + 1'b1 == n_q) ? S_OUT : S_DP_LD;
        end
        S_OUT: begin
          if (out_ready_i) begin
            n_q     <= '0;
            state_q <= S_POP;
          end
        end
        default: state_q <= S_POP;
      endcase
    end
  end
endmodule

// ===== sim/box_stacking_max_height_tb.sv =====
// Testbench for box_stacking_max_height: directed and random box sets checked against a scoreboard.
module box_stacking_max_height_tb import bsm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBoxes  = MaxBoxesDef;
  localparam int unsigned NumSlots  = 3 * NumBoxes;
  localparam int unsigned CycleCap  = 4000000;

  // Expected stack height and overflow flag of one closed set.
  typedef struct {
    logic [HeightW-1:0] height;
    logic               ovf;
  } stack_result_t;

  // Holds the current set of orientations and the queue of expected set results.
  class stack_scoreboard;
    logic [SideW-1:0]   short_q[NumSlots];
    logic [SideW-1:0]   long_q[NumSlots];
    logic [SideW-1:0]   tall_q[NumSlots];
    int unsigned        n_orient;
    bit                 dropped;
    stack_result_t      pending[$];
    int unsigned        n_errors;

    function new();
      n_orient = 0;
      dropped  = 0;
      n_errors = 0;
    endfunction

    function void add_orient(logic [SideW-1:0] x, logic [SideW-1:0] y,
                             logic [SideW-1:0] h);
      short_q[n_orient] = (x < y) ? x : y;
      long_q[n_orient]  = (x < y) ? y : x;
      tall_q[n_orient]  = h;
      n_orient++;
    endfunction

    // Orders by base, then runs the weighted chain pass.
    function logic [HeightW-1:0] tallest();
      logic [SideW-1:0] s, l, h;
      int unsigned best_q[NumSlots];
      int unsigned best, below;
      int j;
      best = 0;
      for (int i = 1; i < n_orient; i++) begin
        s = short_q[i]; l = long_q[i]; h = tall_q[i];
        j = i;
        while (j > 0 && {short_q[j-1], long_q[j-1]} > {s, l}) begin
          short_q[j] = short_q[j-1]; long_q[j] = long_q[j-1]; tall_q[j] = tall_q[j-1];
          j--;
        end
        short_q[j] = s; long_q[j] = l; tall_q[j] = h;
      end
      for (int i = 0; i < n_orient; i++) begin
        below = 0;
        for (int k = 0; k < i; k++)
          if (short_q[k] < short_q[i] && long_q[k] < long_q[i] && best_q[k] > below)
            below = best_q[k];
        below += tall_q[i];
        if (below > HeightMax) below = HeightMax;
        best_q[i] = below;
        if (below > best) best = below;
      end
      return best[HeightW-1:0];
    endfunction

    function void note_box(logic [SideW-1:0] a, logic [SideW-1:0] b,
                           logic [SideW-1:0] c, logic last);
      stack_result_t r;
      if (n_orient + 3 <= NumSlots) begin
        add_orient(a, b, c);
        add_orient(a, c, b);
        add_orient(c, b, a);
      end else begin
        dropped = 1;
      end
      if (last) begin
        r.height = tallest();
        r.ovf    = dropped;
        pending.push_back(r);
        n_orient = 0;
        dropped  = 0;
      end
    endfunction

    function void check_result(logic [HeightW-1:0] height, logic ovf);
      stack_result_t r;
      if (pending.size() == 0) begin
        $error("unexpected result: max_height %0d overflowed %0d", height, ovf);
        n_errors++;
        return;
      end
      r = pending.pop_front();
      if (height !== r.height) begin
        $error("max_height: expected %0d, actual %0d", r.height, height);
        n_errors++;
      end
      if (ovf !== r.ovf) begin
        $error("overflowed: expected %0d, actual %0d", r.ovf, ovf);
        n_errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [SideW-1:0]   side_a_i = '0;
  logic [SideW-1:0]   side_b_i = '0;
  logic [SideW-1:0]   side_c_i = '0;
  logic               last_box_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [HeightW-1:0] max_height_o;
  logic               overflowed_o;

  stack_scoreboard sb = new();
  int unsigned send_idle_pct = 17;   // percent of cycles the sender holds off
  int unsigned recv_idle_pct = 73;   // percent of cycles the receiver stalls
  int unsigned n_cycles = 0;

  box_stacking_max_height u_dut (.*);

  always #10 clk_i = ~clk_i;

  // Global watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleCap) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, checks every accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(max_height_o, overflowed_o);
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drives one box: random idle cycles first, then hold valid until accepted.
  // Valid stays high after acceptance so that a following box goes back to back.
  task automatic send_box(logic [SideW-1:0] a, logic [SideW-1:0] b,
                          logic [SideW-1:0] c, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    side_a_i   <= a;
    side_b_i   <= b;
    side_c_i   <= c;
    last_box_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_box(a, b, c, last);
  endtask

  function automatic logic [SideW-1:0] rand_side();
    case ($urandom_range(3))
      0: return SideW'($urandom_range(15));
      1: return SideW'($urandom_range(300));
      2: return SideW'((($urandom_range(1) == 1) ? 16'hFFFF : 16'h0000) ^
                       $urandom_range(3));
      default: return SideW'($urandom);
    endcase
  endfunction

  // One set of random boxes; mostly small sets, sometimes full or overfull.
  task automatic send_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_box(rand_side(), rand_side(), rand_side(), i == n - 1);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  int unsigned n_sent;
  int unsigned set_len;

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single box, zeros, all ones, equal bases, a nested tower.
    send_box(16'd0, 16'd0, 16'd0, 1'b1);
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_box(16'd5, 16'd5, 16'd5, 1'b0);
    send_box(16'd5, 16'd5, 16'd5, 1'b1);
    send_box(16'd1, 16'd2, 16'd3, 1'b0);
    send_box(16'd4, 16'd5, 16'd6, 1'b0);
    send_box(16'd0, 16'd7, 16'hFFFF, 1'b1);
    // Overflow: the box past capacity is dropped, the last of them too.
    for (int unsigned i = 0; i < NumBoxes + 2; i++)
      send_box(SideW'(16'hFFFF - i), SideW'(16'hFFFE - i), 16'hFFFF,
               i == NumBoxes + 1);
    drain();  // sender holds off until every result has come
    n_sent = 7 + NumBoxes + 2;

    while (n_sent < 457) begin
      if (n_sent > 170 && n_sent < 320) begin
        send_idle_pct = 73; recv_idle_pct = 17;
      end else if (n_sent >= 320) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0: set_len = NumBoxes + $urandom_range(3);
        1: set_len = $urandom_range(NumBoxes / 2, NumBoxes);
        default: set_len = $urandom_range(1, 6);
      endcase
      send_set(set_len);
      n_sent += set_len;
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
src/bsm_pkg.sv
src/bsm_front.sv
src/bsm_fifo.sv
src/bsm_back.sv
src/box_stacking_max_height.sv
sim/box_stacking_max_height_tb.sv
